### rtl/core/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } sha_state_type;

   function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] n);
      rotr = (v >> n) | (v << (6'd32 - {1'b0, n}));
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] r);
      logic [31:0] k [0:63];
      k = '{
         32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
         32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
         32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
         32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
         32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
         32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
         32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
         32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
         32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
         32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
         32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
      round_k = k[r];
   endfunction

   function automatic logic [31:0] start_hash(input logic [2:0] i);
      case (i)
         3'd0: start_hash = 32'h6A09E667;
         3'd1: start_hash = 32'hBB67AE85;
         3'd2: start_hash = 32'h3C6EF372;
         3'd3: start_hash = 32'hA54FF53A;
         3'd4: start_hash = 32'h510E527F;
         3'd5: start_hash = 32'h9B05688C;
         3'd6: start_hash = 32'h1F83D9AB;
         default: start_hash = 32'h5BE0CD19;
      endcase
   endfunction

endpackage

### rtl/core/sha_block_ram.sv
`timescale 1ns / 1ps
// 16 x 32 message word store, one write port, one registered read port.
module sha_block_ram (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [3:0]  wr_addr,
   input  logic [31:0] wr_data,
   input  logic [3:0]  rd_addr,
   output logic [31:0] rd_data
);
   logic [31:0] mem [0:15];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/core/sha256_stream_hasher_unit.sv
`timescale 1ns / 1ps
// Channel | Ports      | Payload (low bit up)
// request | req_t*     | tdata: msg_byte[7:0]; tuser: byte_present, end_of_message
// result  | rsp_t*     | tdata: digest_word[31:0], word_number[34:32]; tlast: last_word
//
// Bytes are taken while idle; the byte that fills a block starts a compression:
// rounds 0-15 each need one word-memory read before the round, rounds 16-63
// need four schedule reads, then the round, and 8 fold steps follow.
// End of message pads one byte a cycle up to the block end, which adds one or
// two compressions; then the 8 digest words leave in order, each while rsp_tready is high.
// Reset is synchronous; it restores the initial hash and clears the count.
// A stalled result holds; no request is taken until all 8 words leave.
module sha256_stream_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // msg_byte
   input  logic [1:0]  req_tuser,   // byte_present, end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word, word_number, zero fill
   output logic        rsp_tlast    // last_word
);
   import sha_pkg::*;

   sha_state_type state_ff, state_in;

   // Bytes gather in a 32-bit word, then go to the word memory.
   logic [31:0] word_acc_ff, word_acc_in;
   logic [63:0] total_ff, total_in;
   logic        fin_ff, fin_in;       // finishing a message
   logic [1:0]  pad_ff, pad_in;       // pad phase: 0 marker, 1 zero, 2 length
   logic [6:0]  cnt_ff, cnt_in;       // round / fold / emit counter
   logic        ph_ff, ph_in;         // round sub-phase
   logic [31:0] h_ff [0:7];
   logic [31:0] v_ff [0:7];
   logic [31:0] w_hold_ff, w_hold_in; // W[r-2]

   logic        wr_en;
   logic [3:0]  wr_addr, rd_addr;
   logic [31:0] wr_data, rd_data;

   sha_block_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic        acc_fire;
   logic [5:0]  pos;
   logic [31:0] s0, s1, w_new, t1, t2;
   logic [5:0]  r;

   assign acc_fire = req_tvalid && req_tready;
   assign pos = total_ff[5:0];
   assign r = cnt_ff[5:0];

   assign s0 = rotr(rd_data, 5'd7) ^ rotr(rd_data, 5'd18) ^ (rd_data >> 3);
   assign s1 = rotr(w_hold_ff, 5'd17) ^ rotr(w_hold_ff, 5'd19) ^ (w_hold_ff >> 10);

   // Rounds 16-63 take four reads, sequenced by a 2-bit step:
   // W[r-2] (held), W[r-15] (sigma sum), W[r-7], then W[r-16] and the round.
   logic [1:0]  st_ff, st_in;
   logic [31:0] acc_ff, acc_in;

   assign t1 = v_ff[7] + (rotr(v_ff[4], 5'd6) ^ rotr(v_ff[4], 5'd11) ^ rotr(v_ff[4], 5'd25))
             + (v_ff[6] ^ (v_ff[4] & (v_ff[5] ^ v_ff[6]))) + round_k(r) + w_new;
   assign t2 = (rotr(v_ff[0], 5'd2) ^ rotr(v_ff[0], 5'd13) ^ rotr(v_ff[0], 5'd22))
             + ((v_ff[0] & v_ff[1]) | (v_ff[2] & (v_ff[0] | v_ff[1])));

   // w_new: for r<16 it is the word read; else acc + rd_data (W[r]).
   assign w_new = (r < 6'd16) ? rd_data : (acc_ff + rd_data);

   // Message bit length, captured while idle so padding does not disturb it.
   logic [63:0] len_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) len_ff <= {total_in[60:0], 3'b000};
   end

   // Set once the block holding the length has been padded.
   logic len_done_ff;
   always_ff @(posedge clock) begin
      if (reset) len_done_ff <= 1'b0;
      else if (state_ff == ST_PAD && pad_ff == 2'd2 && pos == 6'd63) len_done_ff <= 1'b1;
      else if (state_ff == ST_EMIT) len_done_ff <= 1'b0;
   end

   // Read address by step in rounds 16-63: 0 -> r-2, 1 -> r-15, 2 -> r-7, 3 -> r; rounds 0-15 read r.
   always_comb begin
      case (st_ff)
         2'd0: rd_addr = r[3:0] - 4'd2;
         2'd1: rd_addr = r[3:0] - 4'd15;
         2'd2: rd_addr = r[3:0] - 4'd7;
         default: rd_addr = r[3:0];
      endcase
      if (state_ff != ST_ROUND) rd_addr = 4'd0;
      if (state_ff == ST_ROUND && r < 6'd16) rd_addr = r[3:0];
   end

   // round is done in the same cycle that W is available
   logic round_go;
   assign round_go = (state_ff == ST_ROUND) &&
                     ((r < 6'd16) ? (st_ff == 2'd1) : (st_ff == 2'd3 && ph_ff));

   always_comb begin
      state_in    = state_ff;
      word_acc_in = word_acc_ff;
      total_in    = total_ff;
      fin_in      = fin_ff;
      pad_in      = pad_ff;
      cnt_in      = cnt_ff;
      ph_in       = ph_ff;
      st_in       = st_ff;
      acc_in      = acc_ff;
      w_hold_in   = w_hold_ff;
      wr_en       = 1'b0;
      wr_addr     = pos[5:2];
      wr_data     = word_acc_in;
      case (state_ff)
         ST_IDLE: begin
            if (acc_fire) begin
               if (req_tuser[0]) begin
                  word_acc_in = {word_acc_ff[23:0], req_tdata};
                  wr_en = (pos[1:0] == 2'd3);
                  wr_data = {word_acc_ff[23:0], req_tdata};
                  total_in = total_ff + 64'd1;
               end
               fin_in = req_tuser[1];
               pad_in = 2'd0;
               if (req_tuser[0] && pos == 6'd63) begin
                  state_in = ST_ROUND;
                  cnt_in = 7'd0;
                  st_in = 2'd0;
                  ph_in = 1'b0;
               end else if (req_tuser[1]) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // one byte of padding a cycle
            case (pad_ff)
               2'd0: word_acc_in = {word_acc_ff[23:0], 8'h80};
               2'd1: word_acc_in = {word_acc_ff[23:0], 8'h00};
               default: word_acc_in = {word_acc_ff[23:0], len_ff[8'd63 - {pos[2:0], 3'b000} -: 8]};
            endcase
            wr_data = word_acc_in;
            wr_en = (pos[1:0] == 2'd3);
            total_in = total_ff + 64'd1;
            if (pad_ff == 2'd0) pad_in = 2'd1;
            if (pad_in == 2'd1 && pos == 6'd55) pad_in = 2'd2;
            if (pos == 6'd63) begin
               state_in = ST_ROUND;
               cnt_in = 7'd0;
               st_in = 2'd0;
               ph_in = 1'b0;
            end
         end
         ST_ROUND: begin
            if (r < 6'd16) begin
               st_in = st_ff + 2'd1;
               if (st_ff == 2'd1) begin
                  st_in = 2'd0;
                  cnt_in = cnt_ff + 7'd1;
               end
            end else begin
               case (st_ff)
                  2'd0: st_in = 2'd1;
                  2'd1: begin w_hold_in = rd_data; st_in = 2'd2; end
                  2'd2: begin acc_in = s1 + s0; st_in = 2'd3; ph_in = 1'b0; end
                  default: begin
                     if (!ph_ff) begin
                        acc_in = acc_ff + rd_data;
                        ph_in = 1'b1;
                     end else begin
                        wr_en = 1'b1;
                        wr_addr = r[3:0];
                        wr_data = w_new;
                        st_in = 2'd0;
                        cnt_in = cnt_ff + 7'd1;
                     end
                  end
               endcase
            end
            if (round_go && r == 6'd63) begin
               state_in = ST_FOLD;
               cnt_in = 7'd0;
            end
         end
         ST_FOLD: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd7) begin
               cnt_in = 7'd0;
               if (!fin_ff) state_in = ST_IDLE;
               else if (len_done_ff) state_in = ST_EMIT;
               else state_in = ST_PAD;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff == 7'd7) begin
                  state_in = ST_IDLE;
                  fin_in = 1'b0;
                  total_in = 64'd0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= 64'd0;
         fin_ff   <= 1'b0;
         pad_ff   <= 2'd0;
         cnt_ff   <= 7'd0;
         ph_ff    <= 1'b0;
         st_ff    <= 2'd0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         fin_ff   <= fin_in;
         pad_ff   <= pad_in;
         cnt_ff   <= cnt_in;
         ph_ff    <= ph_in;
         st_ff    <= st_in;
      end
      word_acc_ff <= word_acc_in;
      acc_ff    <= acc_in;
      w_hold_ff <= w_hold_in;
   end

   // hash and working variables
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= start_hash(3'(i));
      end else if (state_ff == ST_FOLD) begin
         for (int i = 0; i < 7; i++) h_ff[i] <= h_ff[i + 1];
         h_ff[7] <= h_ff[0] + v_ff[0];
      end else if (state_ff == ST_EMIT && rsp_tready && cnt_ff == 7'd7) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= start_hash(3'(i));
      end
      if (state_ff == ST_ROUND && cnt_ff == 7'd0 && st_ff == 2'd0) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (round_go) begin
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
      end else if (state_ff == ST_FOLD) begin
         for (int i = 0; i < 7; i++) v_ff[i] <= v_ff[i + 1];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {5'd0, cnt_ff[2:0], h_ff[cnt_ff[2:0]]};
   assign rsp_tlast  = (cnt_ff[2:0] == 3'd7);
endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb;
   import sha_pkg::*;

   localparam int TIMEOUT_CYCLES = 20000;
   localparam int TAIL_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [1:0]  req_tuser;   // byte_present, end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // digest_word, word_number, zero fill
   logic        rsp_tlast;   // last_word

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  number;
      logic        last;
   } digest_out_type;

   digest_out_type digest_queue[$];

   // own copy of hasher state
   logic [31:0] cur_hash [8];
   logic [7:0]  blk [64];
   logic [63:0] nbytes;

   int  err_count = 0;
   int  idle_cycles = 0;
   int  req_count = 0;
   int  rsp_count = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_off = 0;

   sha256_stream_hasher_unit u_top (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   localparam logic [31:0] K_TAB [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
      32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
      32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
      32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
      32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
      32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

   localparam logic [31:0] IV_TAB [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

   function automatic logic [31:0] ror32(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   task automatic compress_blk();
      logic [31:0] w [64];
      logic [31:0] a [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      a = cur_hash;
      for (int r = 0; r < 64; r++) begin
         t1 = a[7] + (ror32(a[4], 6) ^ ror32(a[4], 11) ^ ror32(a[4], 25))
            + (a[6] ^ (a[4] & (a[5] ^ a[6]))) + K_TAB[r] + w[r];
         t2 = (ror32(a[0], 2) ^ ror32(a[0], 13) ^ ror32(a[0], 22))
            + ((a[0] & a[1]) | (a[2] & (a[0] | a[1])));
         a[7] = a[6]; a[6] = a[5]; a[5] = a[4]; a[4] = a[3] + t1;
         a[3] = a[2]; a[2] = a[1]; a[1] = a[0]; a[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) cur_hash[i] += a[i];
   endtask

   // predicts the digest words caused by one request
   task automatic predict_digest(logic [7:0] b, logic present, logic fin);
      int unsigned pos;
      logic [63:0] bits;
      if (present) begin
         blk[nbytes[5:0]] = b;
         nbytes++;
         if (nbytes[5:0] == 0) compress_blk();
      end
      if (!fin) return;
      pos = nbytes[5:0];
      blk[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
         while (pos < 64) begin
            blk[pos] = 0;
            pos++;
         end
         compress_blk();
         pos = 0;
      end
      while (pos < 56) begin
         blk[pos] = 0;
         pos++;
      end
      bits = nbytes << 3;
      for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
      compress_blk();
      for (int i = 0; i < 8; i++)
         digest_queue.push_back('{cur_hash[i], 3'(i), i == 7});
      cur_hash = IV_TAB;
      nbytes = 0;
   endtask

   // one request; drive at falling edge, handshake seen at rising edge
   task automatic send_req(logic [7:0] b, logic present, logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= {fin, present};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_digest(b, present, fin);
      req_count++;
      @(negedge clock);
   endtask

   task automatic send_msg(int len);
      for (int i = 0; i < len; i++) send_req(8'($urandom), 1'b1, 1'b0);
      send_req(8'($urandom), 1'b0, 1'b1);
   endtask

   // receiver readiness
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (digest_queue.size() == 0) begin
            $error("unexpected digest word %h", rsp_tdata[31:0]);
            err_count++;
         end else begin
            digest_out_type e;
            e = digest_queue.pop_front();
            if (rsp_tdata[31:0] !== e.word) begin
               $error("digest_word exp %h got %h", e.word, rsp_tdata[31:0]);
               err_count++;
            end
            if (rsp_tdata[34:32] !== e.number) begin
               $error("word_number exp %0d got %0d", e.number, rsp_tdata[34:32]);
               err_count++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last_word exp %0d got %0d", e.last, rsp_tlast);
               err_count++;
            end
         end
      end
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= TIMEOUT_CYCLES) begin
         $display("Watchdog: no progress for %0d cycles", TIMEOUT_CYCLES);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic test_directed();
      send_req(8'h00, 1'b0, 1'b1);            // empty message
      send_req(8'h00, 1'b0, 1'b0);            // no byte, no end: ignored
      send_req(8'h61, 1'b1, 1'b0);            // "abc"
      send_req(8'h62, 1'b1, 1'b0);
      send_req(8'h63, 1'b1, 1'b1);            // byte with end
      send_req(8'hFF, 1'b1, 1'b1);
      send_req(8'h00, 1'b1, 1'b0);
      send_req(8'h55, 1'b0, 1'b0);
      send_req(8'hAA, 1'b1, 1'b1);
   endtask

   // lengths around the one- and two-block padding boundaries
   task automatic test_pad_edges();
      int lens[4] = '{55, 56, 63, 64};
      foreach (lens[i]) send_msg(lens[i]);
   endtask

   task automatic test_random(int n);
      int sent;
      sent = 0;
      while (sent < n) begin
         int len;
         len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(20);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(15) == 0) send_req(8'($urandom), 1'b0, 1'b0);
            send_req(8'($urandom), 1'b1, 1'b0);
         end
         send_req(8'($urandom), 1'($urandom), 1'b1);
         sent += len + 1;
      end
   endtask

   // receiver stalls long while messages keep coming
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         begin
            send_msg(3);
            send_msg(2);
            send_msg(0);
         end
      join
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      cur_hash = IV_TAB;
      nbytes = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 36; recv_idle_pct = 48;
      test_directed();
      test_pad_edges();
      test_random(30);
      send_idle_pct = 48; recv_idle_pct = 36;
      test_backpressure();
      test_random(30);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(30);
      drain();

      $display("Covered empty, short, pad-boundary and multi-block messages under stalls;");
      $display("%0d requests sent, %0d digest words checked", req_count, rsp_count);
      if (err_count == 0 && digest_queue.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### files.f
rtl/core/sha_pkg.sv
rtl/core/sha_block_ram.sv
rtl/core/sha256_stream_hasher_unit.sv
test/tb.sv
